[sv/pmfb_pkg.sv]
// Shared types and operation codes for the page-packed monochrome frame store.
// Used by pmfb_ram and page_packed_mono_framebuffer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pmfb_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_opcode;

    // Rows held by one store byte.
    localparam int PAGE_ROWS = 8;

    localparam t_opcode OP_SET    = 3'd0;
    localparam t_opcode OP_CLR    = 3'd1;
    localparam t_opcode OP_RDPIX  = 3'd2;
    localparam t_opcode OP_CLRALL = 3'd3;
    localparam t_opcode OP_SHIFT  = 3'd4;
    localparam t_opcode OP_RDBYTE = 3'd5;

endpackage

`default_nettype wire

[sv/pmfb_ram.sv]
// Single-port synchronous frame store memory with a registered read port.
// Depends on pmfb_pkg for the byte type.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_addr,
    input  wire pmfb_pkg::t_byte i_wdata,
    output pmfb_pkg::t_byte     o_rdata
);
    import pmfb_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/page_packed_mono_framebuffer.sv]
// Pixel set and clear each do a read-modify-write, and pixel read and byte read each do
// a read, through the single memory port; the result word is registered. Clear all
// writes zero to every store byte. Scroll up makes three single-port memory accesses
// per store byte. After reset the store is swept to zero, one byte a cycle, before the
// first word is taken. Depends on pmfb_pkg and pmfb_ram.
`timescale 1ns / 1ps
`default_nettype none

module page_packed_mono_framebuffer #(
    parameter int WIDTH  = 128,
    parameter int HEIGHT = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire pmfb_pkg::t_opcode i_opcode,
    input  wire logic [7:0]        i_x_pos,
    input  wire logic [7:0]        i_y_pos,
    input  wire logic [7:0]        i_shift_rows,
    input  wire logic [9:0]        i_byte_index,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_pixel_value,
    output logic [7:0]             o_frame_byte
);
    import pmfb_pkg::*;

    localparam int PAGES       = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int AW1         = AW + 1;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RMW    = 3'd2;
    localparam logic [2:0] S_SH_RD1 = 3'd3;
    localparam logic [2:0] S_SH_RD2 = 3'd4;
    localparam logic [2:0] S_SH_WR  = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_report, n_report;
    t_opcode       r_op, n_op;
    logic [2:0]    r_bit, n_bit;
    logic [2:0]    r_sh, n_sh;
    logic [AW:0]   r_off, n_off;
    logic          r_v1, n_v1;
    logic          r_v2, n_v2;
    t_byte         r_lo, n_lo;
    logic          r_res_pix, n_res_pix;
    t_byte         r_res_byte, n_res_byte;
    logic          r_out_valid, n_out_valid;
    logic          r_out_pix, n_out_pix;
    t_byte         r_out_byte, n_out_byte;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_byte         mem_wdata;
    t_byte         mem_rdata;

    logic          accept;
    logic          pix_ok;
    logic          byte_ok;
    logic [AW-1:0] pix_addr;
    logic [AW:0]   src1, src2;
    logic [15:0]   funnel;
    t_byte         hi_byte;
    logic          fin;
    logic          slot_free;

    pmfb_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_pixel_value = r_out_pix;
    assign o_frame_byte  = r_out_byte;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_stall;

    assign pix_ok   = (32'(i_x_pos) < WIDTH) && (32'(i_y_pos) < HEIGHT);
    assign byte_ok  = 32'(i_byte_index) < STORE_BYTES;
    assign pix_addr = AW'(32'(i_x_pos) + 32'(i_y_pos[7:3]) * 32'(WIDTH));

    // Source bytes of a scroll: the page N/8 below, and the page after it.
    assign src1    = {1'b0, r_addr} + r_off;
    assign src2    = src1 + AW1'(WIDTH);
    assign hi_byte = r_v2 ? mem_rdata : 8'd0;
    assign funnel  = {hi_byte, r_lo} >> r_sh;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_report    = r_report;
        n_op        = r_op;
        n_bit       = r_bit;
        n_sh        = r_sh;
        n_off       = r_off;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_lo        = r_lo;
        n_res_pix   = r_res_pix;
        n_res_byte  = r_res_byte;
        n_out_valid = r_out_valid && i_stall;
        n_out_pix   = r_out_pix;
        n_out_byte  = r_out_byte;
        mem_we      = 1'b0;
        mem_addr    = r_addr;
        mem_wdata   = 8'd0;
        fin         = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == AW'(STORE_BYTES - 1)) begin
                    if (r_report) begin
                        fin = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_opcode;
                    n_bit      = i_y_pos[2:0];
                    n_sh       = i_shift_rows[2:0];
                    n_off      = AW1'(32'(i_shift_rows[7:3]) * 32'(WIDTH));
                    n_res_pix  = 1'b0;
                    n_res_byte = 8'd0;
                    n_state    = S_RESP;
                    unique case (i_opcode) inside
                        OP_SET, OP_CLR, OP_RDPIX: begin
                            mem_addr = pix_addr;
                            if (pix_ok) begin
                                n_addr  = pix_addr;
                                n_state = S_RMW;
                            end
                        end
                        OP_RDBYTE: begin
                            mem_addr = AW'(i_byte_index);
                            if (byte_ok) begin
                                n_state = S_RMW;
                            end
                        end
                        OP_CLRALL: begin
                            n_addr   = '0;
                            n_report = 1'b1;
                            n_state  = S_CLEAR;
                        end
                        OP_SHIFT: begin
                            n_addr = '0;
                            if (32'(i_shift_rows) >= HEIGHT) begin
                                n_report = 1'b1;
                                n_state  = S_CLEAR;
                            end else if (i_shift_rows != 8'd0) begin
                                n_state = S_SH_RD1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                case (r_op)
                    OP_SET: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata | (8'd1 << r_bit);
                    end
                    OP_CLR: begin
                        mem_we    = 1'b1;
                        mem_wdata = mem_rdata & ~(8'd1 << r_bit);
                    end
                    OP_RDPIX: n_res_pix = mem_rdata[r_bit];
                    OP_RDBYTE: n_res_byte = mem_rdata;
                    default: begin
                    end
                endcase
                fin = 1'b1;
            end
            S_SH_RD1: begin
                mem_addr = src1[AW-1:0];
                n_v1     = src1 < AW1'(STORE_BYTES);
                n_state  = S_SH_RD2;
            end
            S_SH_RD2: begin
                mem_addr = src2[AW-1:0];
                n_lo     = r_v1 ? mem_rdata : 8'd0;
                n_v2     = src2 < AW1'(STORE_BYTES);
                n_state  = S_SH_WR;
            end
            S_SH_WR: begin
                // Rows past the bottom of the image are always zero in the store,
                // so the funnel brings in blank rows without extra masking.
                mem_we    = 1'b1;
                mem_wdata = funnel[7:0];
                if (r_addr == AW'(STORE_BYTES - 1)) begin
                    fin = 1'b1;
                end else begin
                    n_addr  = AW'(r_addr + 1'b1);
                    n_state = S_SH_RD1;
                end
            end
            S_RESP: begin
                fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out_pix   = n_res_pix;
                n_out_byte  = n_res_byte;
                n_state     = S_IDLE;
            end else begin
                n_state = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_bit      <= n_bit;
        r_sh       <= n_sh;
        r_off      <= n_off;
        r_v1       <= n_v1;
        r_v2       <= n_v2;
        r_lo       <= n_lo;
        r_res_pix  <= n_res_pix;
        r_res_byte <= n_res_byte;
        r_out_pix  <= n_out_pix;
        r_out_byte <= n_out_byte;
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for page_packed_mono_framebuffer: directed and random pixel, clear,
// scroll and byte-read words checked against a shadow copy of the page-packed store.
// Depends on pmfb_pkg and the RTL of the frame store (page_packed_mono_framebuffer, pmfb_ram).
`timescale 1ns / 1ps

module tb_top;
    import pmfb_pkg::*;

    localparam int FB_WIDTH    = 128;
    localparam int FB_HEIGHT   = 64;
    localparam int STORE_BYTES = FB_WIDTH * ((FB_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
    localparam int RANDOM_OPS  = 1600;
    localparam int CALM_TAIL   = 150;
    localparam int PARK_AT     = 500;
    localparam int PARK_CYCLES = 400;
    localparam int SETTLE      = 20;

    // Opcodes the block has no operation for.
    localparam t_opcode OP_SPARE_6 = 3'd6;
    localparam t_opcode OP_SPARE_7 = 3'd7;

    typedef struct packed {
        t_opcode    op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] rows;
        logic [9:0] bi;
        logic       drain;
    } t_frame_cmd;

    typedef struct packed {
        logic       pixel;
        logic [7:0] fbyte;
    } t_frame_answer;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    t_opcode    i_opcode     = OP_SET;
    logic [7:0] i_x_pos      = '0;
    logic [7:0] i_y_pos      = '0;
    logic [7:0] i_shift_rows = '0;
    logic [9:0] i_byte_index = '0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_pixel_value;
    logic [7:0] o_frame_byte;

    logic [7:0]    shadow_store [0:STORE_BYTES-1];
    t_frame_cmd    ops_to_send [$];
    t_frame_answer answers_due [$];
    t_frame_cmd    on_wire;

    int total_ops     = 0;
    int mismatches    = 0;
    int sent_local    = 0;
    int n_sent        = 0;
    int n_done        = 0;
    int send_gap      = 0;
    int send_idle_pct = 15;
    int hold_left     = 0;
    int park_left     = 0;
    int recv_idle_pct = 15;
    bit park_done     = 1'b0;
    bit took;

    always #5 i_clk = ~i_clk;

    page_packed_mono_framebuffer #(
        .WIDTH (FB_WIDTH),
        .HEIGHT(FB_HEIGHT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_shift_rows (i_shift_rows),
        .i_byte_index (i_byte_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_value(o_pixel_value),
        .o_frame_byte (o_frame_byte)
    );

    function automatic void wipe_store();
        for (int a = 0; a < STORE_BYTES; a++) begin
            shadow_store[a] = '0;
        end
    endfunction

    function automatic logic pixel_at(int px, int py);
        if (px >= FB_WIDTH || py >= FB_HEIGHT) begin
            return 1'b0;
        end
        return shadow_store[px + (py / PAGE_ROWS) * FB_WIDTH][py % PAGE_ROWS];
    endfunction

    function automatic void paint_pixel(int px, int py, logic lit);
        if (px < FB_WIDTH && py < FB_HEIGHT) begin
            shadow_store[px + (py / PAGE_ROWS) * FB_WIDTH][py % PAGE_ROWS] = lit;
        end
    endfunction

    // Applies one word to the shadow store and returns the result word it must produce.
    function automatic t_frame_answer apply_frame_op(t_frame_cmd c);
        t_frame_answer ans;
        int n;
        ans = '0;
        n = int'(c.rows);
        case (c.op)
            OP_SET: begin
                paint_pixel(int'(c.x), int'(c.y), 1'b1);
            end
            OP_CLR: begin
                paint_pixel(int'(c.x), int'(c.y), 1'b0);
            end
            OP_RDPIX: begin
                ans.pixel = pixel_at(int'(c.x), int'(c.y));
            end
            OP_CLRALL: begin
                wipe_store();
            end
            OP_SHIFT: begin
                if (n >= FB_HEIGHT) begin
                    wipe_store();
                end else if (n != 0) begin
                    // Rows go upward, so a source row is always read before it is overwritten.
                    for (int py = 0; py < FB_HEIGHT; py++) begin
                        for (int px = 0; px < FB_WIDTH; px++) begin
                            paint_pixel(px, py,
                                (py + n < FB_HEIGHT) ? pixel_at(px, py + n) : 1'b0);
                        end
                    end
                end
            end
            OP_RDBYTE: begin
                if (int'(c.bi) < STORE_BYTES) begin
                    ans.fbyte = shadow_store[c.bi];
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 45;
        endcase
    endfunction

    // Mostly pixel traffic, half of it in a small corner so that reads find lit pixels.
    function automatic t_frame_cmd random_cmd();
        t_frame_cmd c;
        int roll;
        int spot;
        roll = $urandom_range(999);
        if (roll < 350) begin
            c.op = OP_SET;
        end else if (roll < 500) begin
            c.op = OP_CLR;
        end else if (roll < 750) begin
            c.op = OP_RDPIX;
        end else if (roll < 920) begin
            c.op = OP_RDBYTE;
        end else if (roll < 950) begin
            c.op = OP_SHIFT;
        end else if (roll < 965) begin
            c.op = OP_CLRALL;
        end else if (roll < 982) begin
            c.op = OP_SPARE_6;
        end else begin
            c.op = OP_SPARE_7;
        end
        spot = $urandom_range(99);
        if (spot < 50) begin
            c.x = 8'($urandom_range(15));
            c.y = 8'($urandom_range(15));
        end else if (spot < 85) begin
            c.x = 8'($urandom_range(FB_WIDTH - 1));
            c.y = 8'($urandom_range(FB_HEIGHT - 1));
        end else begin
            c.x = 8'($urandom_range(255));
            c.y = 8'($urandom_range(255));
        end
        c.rows = ($urandom_range(9) < 7) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
        if ($urandom_range(1) == 0) begin
            c.bi = 10'($urandom_range(15) + FB_WIDTH * $urandom_range(1));
        end else begin
            c.bi = 10'($urandom_range(1023));
        end
        c.drain = 1'b0;
        return c;
    endfunction

    task automatic push_cmd(t_opcode op, int x, int y, int rows, int bi);
        t_frame_cmd c;
        c.op    = op;
        c.x     = 8'(x);
        c.y     = 8'(y);
        c.rows  = 8'(rows);
        c.bi    = 10'(bi);
        c.drain = 1'b0;
        ops_to_send.push_back(c);
    endtask

    // Sender: holds a stalled word, predicts each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                answers_due.push_back(apply_frame_op(on_wire));
                sent_local = sent_local + 1;
                n_sent <= sent_local;
            end
            if (!i_valid || took) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else if (ops_to_send.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (ops_to_send[0].drain && n_done != sent_local) begin
                    i_valid <= 1'b0;
                end else if (ops_to_send.size() > CALM_TAIL
                             && $urandom_range(99) < send_idle_pct) begin
                    send_gap = $urandom_range(6);
                    i_valid <= 1'b0;
                end else begin
                    on_wire = ops_to_send.pop_front();
                    i_valid      <= 1'b1;
                    i_opcode     <= on_wire.op;
                    i_x_pos      <= on_wire.x;
                    i_y_pos      <= on_wire.y;
                    i_shift_rows <= on_wire.rows;
                    i_byte_index <= on_wire.bi;
                    if ($urandom_range(63) == 0) begin
                        send_idle_pct = pick_idle_pct();
                    end
                end
            end
        end
    end

    // Receiver back-pressure, including one long hold-off that fills the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (park_left > 0) begin
            park_left = park_left - 1;
            i_stall <= 1'b1;
        end else if (!park_done && n_done >= PARK_AT) begin
            park_done = 1'b1;
            park_left = PARK_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (n_done < total_ops - CALM_TAIL && $urandom_range(99) < recv_idle_pct) begin
            hold_left = $urandom_range(6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(63) == 0) begin
                recv_idle_pct = pick_idle_pct();
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $error("result word with nothing expected");
                mismatches = mismatches + 1;
            end else begin
                want = answers_due.pop_front();
                if (o_pixel_value !== want.pixel) begin
                    $error("pixel_value: expected %0d, got %0d", want.pixel, o_pixel_value);
                    mismatches = mismatches + 1;
                end
                if (o_frame_byte !== want.fbyte) begin
                    $error("frame_byte: expected 0x%02h, got 0x%02h", want.fbyte, o_frame_byte);
                    mismatches = mismatches + 1;
                end
            end
            n_done <= n_done + 1;
        end
    end

    initial begin
        t_frame_cmd c;
        wipe_store();

        // Corners, out-of-range coordinates, zero and large scrolls, spare opcodes.
        push_cmd(OP_SET,      0,   0,   0,    0);
        push_cmd(OP_SET,    127,  63,   0,    0);
        push_cmd(OP_RDPIX,    0,   0,   0,    0);
        push_cmd(OP_RDPIX,  127,  63,   0,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0, 1023);
        push_cmd(OP_SET,    128,   0,   0,    0);
        push_cmd(OP_SET,      0,  64,   0,    0);
        push_cmd(OP_SET,    255, 255, 255, 1023);
        push_cmd(OP_RDPIX,  255, 255,   0,    0);
        push_cmd(OP_RDPIX,  128,   0,   0,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0,  128);
        push_cmd(OP_CLR,      0,   0,   0,    0);
        push_cmd(OP_RDPIX,    0,   0,   0,    0);
        push_cmd(OP_SHIFT,    0,   0,   0,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0, 1023);
        push_cmd(OP_SET,      5,  10,   0,    0);
        push_cmd(OP_SHIFT,    0,   0,   3,    0);
        push_cmd(OP_RDPIX,    5,   7,   0,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0, 1023);
        push_cmd(OP_SPARE_6,  9,   9,   9,    9);
        push_cmd(OP_SPARE_7, 255, 255, 255, 1023);
        push_cmd(OP_SHIFT,    0,   0,  64,    0);
        push_cmd(OP_RDBYTE,   0,   0,   0,    5);
        push_cmd(OP_CLRALL,   0,   0,   0,    0);

        for (int k = 0; k < RANDOM_OPS; k++) begin
            c = random_cmd();
            // The sender waits for every result before these words.
            c.drain = (k == 0) || (k == (RANDOM_OPS * 2) / 3);
            ops_to_send.push_back(c);
        end
        total_ops = ops_to_send.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != total_ops || n_done != n_sent) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d result words never arrived", answers_due.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
